// ===== rtl/auip_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// auip_pkg: shared types and constants of the ASCII unsigned integer parser
// Character codes, the classified character record passed from the front
// end to the conversion engine, the queue status group and the phase type.
// ----------------------------------------------------------------------------
package auip_pkg;

   // character codes
   localparam logic [7:0] CH_DIGIT_0  = 8'h30;  // '0'
   localparam logic [7:0] CH_DIGIT_9  = 8'h39;  // '9'
   localparam logic [7:0] CH_UPPER_A  = 8'h41;  // 'A'
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;  // 'Z'
   localparam logic [7:0] CH_LOWER_A  = 8'h61;  // 'a'
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;  // 'z'
   localparam logic [7:0] CH_LOWER_X  = 8'h78;  // 'x'
   localparam logic [7:0] CH_UPPER_X  = 8'h58;  // 'X'
   localparam logic [7:0] CH_PLUS     = 8'h2B;  // '+'
   localparam logic [7:0] CH_MINUS    = 8'h2D;  // '-'
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_VT       = 8'h0B;
   localparam logic [7:0] CH_FF       = 8'h0C;
   localparam logic [7:0] CH_CR       = 8'h0D;

   // letter digit offset ('A' and 'a' weigh ten)
   localparam logic [7:0] LETTER_BIAS = 8'd10;

   // radix codes
   localparam logic [5:0] RADIX_AUTO  = 6'd0;
   localparam logic [5:0] RADIX_OCT   = 6'd8;
   localparam logic [5:0] RADIX_DEC   = 6'd10;
   localparam logic [5:0] RADIX_HEX   = 6'd16;

   // field widths of the input item
   localparam int CH_BITS    = 8;
   localparam int BASE_BITS  = 6;
   localparam int DIGIT_BITS = 6;

   // queue between front end and engine
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QLVL_BITS   = $clog2(QUEUE_DEPTH + 1);

   // one classified character
   typedef struct packed {
      logic                  start;
      logic [BASE_BITS-1:0]  base;
      logic                  blank;
      logic                  sign;
      logic                  minus;
      logic                  zero;
      logic                  xchar;
      logic                  alnum;
      logic [DIGIT_BITS-1:0] dval;
   } item_type;

   // queue status
   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QLVL_BITS-1:0] level;
   } qstat_type;

   // conversion phase
   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_SPACE  = 5'b00010,
      PH_PREFIX = 5'b00100,
      PH_ZERO   = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

endpackage
`default_nettype wire

// ===== rtl/auip_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// auip_front: character intake and classification
// Takes characters off the input stream, sorts each into blank, sign, zero,
// x, alphanumeric with its digit weight, and pushes the record to the queue.
// ----------------------------------------------------------------------------
module auip_front (
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [auip_pkg::CH_BITS-1:0]   ch,
   input  wire logic [auip_pkg::BASE_BITS-1:0] base,
   input  wire logic                           start_req,
   input  wire auip_pkg::qstat_type            q_stat,
   output logic                                q_push,
   output auip_pkg::item_type                  q_item
);

   // flow control: take a character whenever the queue has room
   assign req_tready = !q_stat.full;
   assign q_push     = req_tvalid && !q_stat.full;

   // classification
   always_comb begin
      logic [7:0] wt;
      wt = 8'd0;
      q_item       = '0;
      q_item.start = start_req;
      q_item.base  = base;
      q_item.blank = (ch == auip_pkg::CH_SPACE) || (ch == auip_pkg::CH_TAB) ||
                     (ch == auip_pkg::CH_LF)    || (ch == auip_pkg::CH_VT)  ||
                     (ch == auip_pkg::CH_FF)    || (ch == auip_pkg::CH_CR);
      q_item.sign  = (ch == auip_pkg::CH_PLUS) || (ch == auip_pkg::CH_MINUS);
      q_item.minus = (ch == auip_pkg::CH_MINUS);
      q_item.zero  = (ch == auip_pkg::CH_DIGIT_0);
      q_item.xchar = (ch == auip_pkg::CH_LOWER_X) || (ch == auip_pkg::CH_UPPER_X);
      if (ch inside {[auip_pkg::CH_DIGIT_0:auip_pkg::CH_DIGIT_9]}) begin
         q_item.alnum = 1'b1;
         wt = ch - auip_pkg::CH_DIGIT_0;
      end else if (ch inside {[auip_pkg::CH_UPPER_A:auip_pkg::CH_UPPER_Z]}) begin
         q_item.alnum = 1'b1;
         wt = ch - auip_pkg::CH_UPPER_A + auip_pkg::LETTER_BIAS;
      end else if (ch inside {[auip_pkg::CH_LOWER_A:auip_pkg::CH_LOWER_Z]}) begin
         q_item.alnum = 1'b1;
         wt = ch - auip_pkg::CH_LOWER_A + auip_pkg::LETTER_BIAS;
      end
      q_item.dval = wt[auip_pkg::DIGIT_BITS-1:0];
   end

endmodule
`default_nettype wire

// ===== rtl/auip_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// auip_queue: short queue of classified characters
// Decouples the intake from the conversion engine; push and pop may happen
// in the same cycle, but the intake does not push while the queue is full.
// ----------------------------------------------------------------------------
module auip_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire auip_pkg::item_type push_item,
   input  wire logic               pop,
   output auip_pkg::item_type      head_item,
   output auip_pkg::qstat_type     stat
);

   auip_pkg::item_type                slot_ff [auip_pkg::QUEUE_DEPTH];
   logic [auip_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [auip_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [auip_pkg::QLVL_BITS-1:0]    level_ff, level_in;

   // pointer and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = slot_ff[rd_ptr_ff];
   assign stat.level = level_ff;
   assign stat.empty = (level_ff == '0);
   assign stat.full  = (level_ff == auip_pkg::QLVL_BITS'(auip_pkg::QUEUE_DEPTH));

endmodule
`default_nettype wire

// ===== rtl/auip_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// auip_back: conversion engine and result register
// Steps the phase machine (white space, sign, prefix, digits) over one
// queued character per cycle while the result slot is free or draining,
// does the radix multiply-add, and registers the finished value and offset.
// ----------------------------------------------------------------------------
module auip_back #(
   parameter int WORD_BITS   = 32,
   parameter int OFFSET_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire auip_pkg::item_type     head_item,
   input  wire auip_pkg::qstat_type    q_stat,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [WORD_BITS-1:0]        rsp_value,
   output logic [OFFSET_BITS-1:0]      rsp_offset
);

   localparam int PROD_BITS = WORD_BITS + auip_pkg::BASE_BITS;

   auip_pkg::phase_type                phase_ff, phase_in;
   logic [auip_pkg::BASE_BITS-1:0]     radix_ff, radix_in;
   logic [WORD_BITS-1:0]               acc_ff, acc_in;
   logic                               neg_ff, neg_in;
   logic [OFFSET_BITS-1:0]             cnt_ff, cnt_in;
   logic                               emit;
   logic [WORD_BITS-1:0]               emit_value;
   logic [OFFSET_BITS-1:0]             emit_offset;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]               rsp_value_ff;
   logic [OFFSET_BITS-1:0]             rsp_offset_ff;

   // take the next character when the result slot is free or draining
   assign q_pop = !q_stat.empty && (!rsp_valid_ff || rsp_tready);

   // phase machine for one character
   always_comb begin
      logic                 done;
      logic                 bump;
      logic [PROD_BITS-1:0] prod;
      done     = 1'b0;
      bump     = 1'b0;
      prod     = '0;
      emit     = 1'b0;
      phase_in = phase_ff;
      radix_in = radix_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;

      // start flag opens a new string, dropping any conversion in flight
      if (head_item.start) begin
         phase_in = auip_pkg::PH_SPACE;
         radix_in = head_item.base;
         acc_in   = '0;
         neg_in   = 1'b0;
         cnt_in   = '0;
      end

      if (phase_in == auip_pkg::PH_IDLE) begin
         done = 1'b1;
      end

      // leading white space and optional sign
      if (!done && phase_in == auip_pkg::PH_SPACE) begin
         if (head_item.blank) begin
            bump = 1'b1;
            done = 1'b1;
         end else if (head_item.sign) begin
            neg_in   = head_item.minus;
            bump     = 1'b1;
            phase_in = auip_pkg::PH_PREFIX;
            done     = 1'b1;
         end else begin
            phase_in = auip_pkg::PH_PREFIX;
         end
      end

      // leading zero for auto or hex radix
      if (!done && phase_in == auip_pkg::PH_PREFIX) begin
         if ((radix_in == auip_pkg::RADIX_AUTO || radix_in == auip_pkg::RADIX_HEX) &&
             head_item.zero) begin
            bump     = 1'b1;
            phase_in = auip_pkg::PH_ZERO;
            done     = 1'b1;
         end else begin
            if (radix_in == auip_pkg::RADIX_AUTO) begin
               radix_in = auip_pkg::RADIX_DEC;
            end
            phase_in = auip_pkg::PH_DIGITS;
         end
      end

      // x after the zero selects hex, otherwise auto falls to octal
      if (!done && phase_in == auip_pkg::PH_ZERO) begin
         if (head_item.xchar) begin
            bump     = 1'b1;
            radix_in = auip_pkg::RADIX_HEX;
            phase_in = auip_pkg::PH_DIGITS;
            done     = 1'b1;
         end else begin
            if (radix_in == auip_pkg::RADIX_AUTO) begin
               radix_in = auip_pkg::RADIX_OCT;
            end
            phase_in = auip_pkg::PH_DIGITS;
         end
      end

      // digits: multiply-add, or terminate on the first non-digit
      if (!done) begin
         if (head_item.alnum && (head_item.dval < radix_in)) begin
            prod   = PROD_BITS'(acc_in) * PROD_BITS'(radix_in);
            acc_in = prod[WORD_BITS-1:0] + WORD_BITS'(head_item.dval);
            bump   = 1'b1;
         end else begin
            emit     = 1'b1;
            phase_in = auip_pkg::PH_IDLE;
         end
      end

      emit_value  = neg_in ? ('0 - acc_in) : acc_in;
      emit_offset = cnt_in;

      // saturating consumed count
      if (bump && (cnt_in != '1)) begin
         cnt_in = cnt_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= auip_pkg::PH_IDLE;
         radix_ff <= '0;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else if (q_pop) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         cnt_ff   <= cnt_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (q_pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_value_ff  <= emit_value;
         rsp_offset_ff <= emit_offset;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_offset = rsp_offset_ff;

endmodule
`default_nettype wire

// ===== rtl/ascii_unsigned_integer_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_unsigned_integer_parser: streaming string to unsigned integer
//
//   channel   direction  tdata (low bit up)                 tuser
//   req_      in         ch[7:0], base[13:8], zero pad      start_req
//   rsp_      out        value, end_offset, zero pad to     -
//                        whole bytes
//
// One character per cycle sustained while the result stream takes results;
// the radix multiply-add in the engine is the one step per character.
// A result is registered: its terminating character is written into the
// queue, popped by the engine, and the result register loads on that pop.
// Reset is synchronous and clears the queue, phase and result valid.
// A stalled result stops the engine; the four-entry queue keeps taking
// characters until it fills.
// ----------------------------------------------------------------------------
module ascii_unsigned_integer_parser #(
   parameter int WORD_BITS   = 32,
   parameter int OFFSET_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // character stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // ch[7:0], base[13:8], pad
   input  wire logic                  req_tuser,   // start_req
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [((WORD_BITS + OFFSET_BITS + 7) / 8) * 8 - 1:0]
                                      rsp_tdata    // value, end_offset, pad
);

   localparam int RSP_BITS = ((WORD_BITS + OFFSET_BITS + 7) / 8) * 8;

   auip_pkg::item_type        push_item;
   auip_pkg::item_type        head_item;
   auip_pkg::qstat_type       q_stat;
   logic                      q_push;
   logic                      q_pop;
   logic [WORD_BITS-1:0]      rsp_value;
   logic [OFFSET_BITS-1:0]    rsp_offset;

   // intake and classification
   auip_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .ch         (req_tdata[auip_pkg::CH_BITS-1:0]),
      .base       (req_tdata[auip_pkg::CH_BITS +: auip_pkg::BASE_BITS]),
      .start_req  (req_tuser),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // decoupling queue
   auip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   // conversion engine
   auip_back #(
      .WORD_BITS   (WORD_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_offset (rsp_offset)
   );

   assign rsp_tdata = RSP_BITS'({rsp_offset, rsp_value});

`ifndef SYNTH
   // engine never reads an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("engine popped an empty queue");

   // fill level tracks pushes and pops
   a_level_track: assert property (@(posedge clock) disable iff (reset)
      !reset |=> q_stat.level == $past(q_stat.level + auip_pkg::QLVL_BITS'(q_push)
                                       - auip_pkg::QLVL_BITS'(q_pop)))
      else $error("queue level out of step with transfers");

   // a new result only comes from a character the engine just took
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(q_pop))
      else $error("result appeared without a consumed character");
`endif

endmodule
`default_nettype wire
